[src/uuid_string_parser_core_assert.svh]
// ---------------------------------------------------------------------------
// uuid_string_parser_core assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef UUID_STRING_PARSER_CORE_ASSERT_SVH
`define UUID_STRING_PARSER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define USP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("usp check failed");

// next-cycle implication, disabled in reset
`define USP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("usp check failed");

`endif

[src/usp_pkg.sv]
// ---------------------------------------------------------------------------
// usp_pkg
// Types, character constants and decode functions of the UUID text parser.
// ---------------------------------------------------------------------------
package usp_pkg;

	typedef logic [5:0] count_t;
	typedef logic [3:0] form_flags_t;

	localparam int FORM_CANON = 0;
	localparam int FORM_BRACE = 1;
	localparam int FORM_URN   = 2;
	localparam int FORM_RAW   = 3;

	localparam count_t LEN_CANON = 6'd36;
	localparam count_t LEN_BRACE = 6'd38;
	localparam count_t LEN_URN   = 6'd45;
	localparam count_t LEN_RAW   = 6'd32;
	localparam count_t COUNT_MAX = 6'd63;
	localparam count_t URN_LEN   = 6'd9;

	localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
	localparam logic [7:0] CHAR_LBRACE = 8'h7B;
	localparam logic [7:0] CHAR_RBRACE = 8'h7D;

	localparam logic [7:0] MASK_C0 = 8'hC0;
	localparam logic [7:0] MASK_E0 = 8'hE0;
	localparam logic [7:0] PAT_80  = 8'h80;

	typedef enum logic [1:0] {
		VAR_NCS     = 2'd0,
		VAR_RFC4122 = 2'd1,
		VAR_VENDOR  = 2'd2,
		VAR_FUTURE  = 2'd3
	} variant_t;

	// "urn:uuid:" in lower case
	localparam logic [7:0] URN_PREFIX [9] = '{
		8'h75, 8'h72, 8'h6E, 8'h3A, 8'h75, 8'h75, 8'h69, 8'h64, 8'h3A
	};

	function automatic logic is_digit(input logic [7:0] ch);
		return (ch >= 8'h30) && (ch <= 8'h39);
	endfunction

	function automatic logic is_hex(input logic [7:0] ch);
		return is_digit(ch) || ((ch >= 8'h61) && (ch <= 8'h66))
			|| ((ch >= 8'h41) && (ch <= 8'h46));
	endfunction

	// letters a..f and A..F share the low nibble 1..6
	function automatic logic [3:0] nibble_of(input logic [7:0] ch);
		return is_digit(ch) ? ch[3:0] : ch[3:0] + 4'd9;
	endfunction

	function automatic logic [7:0] lower_ascii(input logic [7:0] ch);
		return ((ch >= 8'h41) && (ch <= 8'h5A)) ? ch + 8'd32 : ch;
	endfunction

	// byte at offset q of an 8-4-4-4-12 span
	function automatic logic canon_ok(input count_t q, input logic [7:0] ch);
		logic dash_pos;
		dash_pos = (q == 6'd8) || (q == 6'd13) || (q == 6'd18) || (q == 6'd23);
		return dash_pos ? (ch == CHAR_HYPHEN) : is_hex(ch);
	endfunction

	function automatic variant_t variant_of(input logic [7:0] b);
		variant_t v;
		if ((b & MASK_C0) == PAT_80)
			v = VAR_RFC4122;
		else if ((b & MASK_E0) == MASK_C0)
			v = VAR_VENDOR;
		else if ((b & MASK_E0) == MASK_E0)
			v = VAR_FUTURE;
		else
			v = VAR_NCS;
		return v;
	endfunction

endpackage

[src/usp_if.sv]
// ---------------------------------------------------------------------------
// usp_char_if / usp_res_if
// Valid/ready channels for text bytes and parse results.
// ---------------------------------------------------------------------------
interface usp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       last_char;

	modport source (output valid, output char_in, output last_char, input ready);
	modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface usp_res_if;
	logic        valid;
	logic        ready;
	logic        valid_res;
	logic [63:0] uuid_high;
	logic [63:0] uuid_low;
	logic [3:0]  version_nibble;
	logic [1:0]  variant_code;

	modport source (output valid, output valid_res, output uuid_high, output uuid_low,
		output version_nibble, output variant_code, input ready);
	modport sink   (input valid, input valid_res, input uuid_high, input uuid_low,
		input version_nibble, input variant_code, output ready);
endinterface

[src/uuid_string_parser_core.sv]
// ---------------------------------------------------------------------------
// uuid_string_parser_core
// The result of a last byte is valid in the cycle after that byte is taken.
// Throughput: one byte per cycle, stalled while a result waits and is not taken.
// The byte update is a nibble shift plus compares; a byte is still taken if the result is.
// Reset (arst_n low): count and shift cleared, all forms armed, no result pending.
// ---------------------------------------------------------------------------
`include "uuid_string_parser_core_assert.svh"

module uuid_string_parser_core (
	input  logic          clk,
	input  logic          arst_n,
	usp_char_if.sink      chars,
	usp_res_if.source     results
);

	logic                  accept;
	usp_pkg::count_t       count_q, count_d;
	usp_pkg::form_flags_t  flags_q, flags_d;
	logic [63:0]           hi_q, lo_q, hi_d, lo_d;
	logic                  hex;
	logic                  ok;
	usp_pkg::count_t       p;
	logic                  res_valid_q;

	assign chars.ready = !res_valid_q || results.ready;
	assign accept      = chars.valid && chars.ready;
	assign p           = count_q;

	always_comb begin
		flags_d = flags_q;
		hex     = usp_pkg::is_hex(chars.char_in);

		if (p < usp_pkg::LEN_CANON && !usp_pkg::canon_ok(p, chars.char_in))
			flags_d[usp_pkg::FORM_CANON] = 1'b0;

		if (p == 6'd0) begin
			if (chars.char_in != usp_pkg::CHAR_LBRACE)
				flags_d[usp_pkg::FORM_BRACE] = 1'b0;
		end else if (p < usp_pkg::LEN_CANON + 6'd1) begin
			if (!usp_pkg::canon_ok(p - 6'd1, chars.char_in))
				flags_d[usp_pkg::FORM_BRACE] = 1'b0;
		end else if (p == usp_pkg::LEN_CANON + 6'd1) begin
			if (chars.char_in != usp_pkg::CHAR_RBRACE)
				flags_d[usp_pkg::FORM_BRACE] = 1'b0;
		end

		if (p < usp_pkg::URN_LEN) begin
			if (usp_pkg::lower_ascii(chars.char_in) != usp_pkg::URN_PREFIX[p[3:0]])
				flags_d[usp_pkg::FORM_URN] = 1'b0;
		end else if (p < usp_pkg::LEN_URN) begin
			if (!usp_pkg::canon_ok(p - usp_pkg::URN_LEN, chars.char_in))
				flags_d[usp_pkg::FORM_URN] = 1'b0;
		end

		if (p < usp_pkg::LEN_RAW && !hex)
			flags_d[usp_pkg::FORM_RAW] = 1'b0;

		// shift one hex digit into the 128-bit window
		if (hex) begin
			hi_d = {hi_q[59:0], lo_q[63:60]};
			lo_d = {lo_q[59:0], usp_pkg::nibble_of(chars.char_in)};
		end else begin
			hi_d = hi_q;
			lo_d = lo_q;
		end

		count_d = (p != usp_pkg::COUNT_MAX) ? p + 6'd1 : p;

		case (count_d)
			usp_pkg::LEN_CANON: ok = flags_d[usp_pkg::FORM_CANON];
			usp_pkg::LEN_BRACE: ok = flags_d[usp_pkg::FORM_BRACE];
			usp_pkg::LEN_URN:   ok = flags_d[usp_pkg::FORM_URN];
			usp_pkg::LEN_RAW:   ok = flags_d[usp_pkg::FORM_RAW];
			default:            ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			flags_q <= '1;
			hi_q    <= '0;
			lo_q    <= '0;
		end else if (accept) begin
			// rearm after the last byte, valid or not
			if (chars.last_char) begin
				count_q <= '0;
				flags_q <= '1;
				hi_q    <= '0;
				lo_q    <= '0;
			end else begin
				count_q <= count_d;
				flags_q <= flags_d;
				hi_q    <= hi_d;
				lo_q    <= lo_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && chars.last_char) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload, zero when the text is malformed
	always_ff @(posedge clk) begin
		if (accept && chars.last_char) begin
			results.valid_res      <= ok;
			results.uuid_high      <= ok ? hi_d : 64'd0;
			results.uuid_low       <= ok ? lo_d : 64'd0;
			results.version_nibble <= ok ? hi_d[15:12] : 4'd0;
			results.variant_code   <= ok ? usp_pkg::variant_of(lo_d[63:56])
				: usp_pkg::VAR_NCS;
		end
	end

	assign results.valid = res_valid_q;

	`USP_ASSERT_NXT(a_last_gives_result, clk, arst_n,
		accept && chars.last_char, res_valid_q)
	`USP_ASSERT_NXT(a_last_rearms, clk, arst_n,
		accept && chars.last_char, count_q == 6'd0 && flags_q == 4'hF)
	`USP_ASSERT_IMP(a_invalid_is_zero, clk, arst_n,
		res_valid_q && !results.valid_res,
		results.uuid_high == 64'd0 && results.uuid_low == 64'd0
			&& results.version_nibble == 4'd0 && results.variant_code == 2'd0)

endmodule
